// ===== src/ttu_pkg.sv =====
// Shared types, constants and effect translation for the track unpacker.
package ttu_pkg;

   localparam int ROW_MAX     = 256;
   localparam int ROW_W       = 9;
   localparam int ADDR_W      = 8;
   localparam int RUN_W       = 6;
   localparam logic [ROW_W-1:0] ROW_COUNT_RESET = 9'd64;
   localparam logic [7:0] NOTE_LIMIT = 8'd108;

   localparam logic [1:0] ACT_SKIP   = 2'd0;
   localparam logic [1:0] ACT_REPEAT = 2'd1;
   localparam logic [1:0] ACT_COPY   = 2'd2;
   localparam logic [1:0] ACT_FULL   = 2'd3;

   localparam logic [4:0] EFF_NONE     = 5'd0;
   localparam logic [4:0] EFF_PORTA_UP = 5'd1;
   localparam logic [4:0] EFF_PORTA_DN = 5'd2;
   localparam logic [4:0] EFF_TONE     = 5'd3;
   localparam logic [4:0] EFF_VIBRATO  = 5'd4;
   localparam logic [4:0] EFF_ARP      = 5'd5;
   localparam logic [4:0] EFF_SPEED    = 5'd6;
   localparam logic [4:0] EFF_TEMPO    = 5'd7;
   localparam logic [4:0] EFF_PAN      = 5'd8;
   localparam logic [4:0] EFF_JUMP     = 5'd9;
   localparam logic [4:0] EFF_GLOBVOL  = 5'd10;
   localparam logic [4:0] EFF_BREAK    = 5'd11;
   localparam logic [4:0] EFF_EXT      = 5'd12;
   localparam logic [4:0] EFF_PANSL    = 5'd13;
   localparam logic [4:0] EFF_RETRIG   = 5'd14;
   localparam logic [4:0] EFF_GVSL     = 5'd15;
   localparam logic [4:0] EFF_VOLSL    = 5'd16;
   localparam logic [4:0] EFF_TREMOLO  = 5'd17;
   localparam logic [4:0] EFF_TREMOR   = 5'd18;
   localparam logic [4:0] EFF_OFFSET   = 5'd19;

   localparam logic [7:0] RAW_OFFSET = 8'hEF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SRC_EMPTY,
      SRC_MEM,
      SRC_BUILD
   } src_type;

   typedef struct packed {
      logic [7:0] note;
      logic [7:0] instr;
      logic       vol_on;
      logic [6:0] vol;
      logic [4:0] eff;
      logic [7:0] par;
   } cell_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic take;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic last;
   } status_type;

   // {code, param}; code of none means the cell is left as is
   function automatic logic [12:0] map_effect(input logic [7:0] eff, input logic [11:0] data);
      logic [4:0]  code;
      logic [11:0] p;
      logic [7:0]  hi;
      logic [3:0]  lo;
      logic [7:0]  tens;
      begin
         code = EFF_NONE;
         p    = data;
         hi   = data[7:0] & 8'hF0;
         lo   = data[3:0];
         tens = {1'b0, data[7:4], 3'b000} + {3'b000, data[7:4], 1'b0};
         case (eff)
            8'h01: code = EFF_PORTA_UP;
            8'h02: code = EFF_PORTA_DN;
            8'h03: code = EFF_TONE;
            8'h04: code = EFF_VIBRATO;
            8'h05: code = EFF_ARP;
            8'h07: code = (data < 12'h020) ? EFF_SPEED : EFF_TEMPO;
            8'h08: begin
               code = EFF_PAN;
               p    = {p[10:0], 1'b0};
            end
            8'h0B: code = EFF_JUMP;
            8'h0C: code = EFF_GLOBVOL;
            8'h0D: begin
               code = EFF_BREAK;
               p    = {4'd0, tens + {4'd0, lo}};
            end
            8'h0E: begin
               code = EFF_EXT;
               case (hi)
                  8'h00: code = EFF_NONE;
                  8'h10: begin
                     if (lo != 4'd0) begin
                        p    = p | 12'h0F0;
                        code = EFF_PANSL;
                     end else begin
                        code = EFF_NONE;
                     end
                  end
                  8'h20: begin
                     if (lo != 4'd0) begin
                        p    = {4'd0, lo, 4'hF};
                        code = EFF_PANSL;
                     end else begin
                        code = EFF_NONE;
                     end
                  end
                  8'h30: p = {8'h01, lo};
                  8'h40: p = {8'h03, lo};
                  8'h60: p = {8'h0B, lo};
                  8'h70: p = {8'h04, lo};
                  8'h90: begin
                     code = EFF_RETRIG;
                     p    = {8'd0, lo};
                  end
                  8'hA0: begin
                     code = EFF_GVSL;
                     p    = {4'd0, lo, 4'd0};
                  end
                  8'hB0: begin
                     code = EFF_GVSL;
                     p    = {8'd0, lo};
                  end
                  8'hF0: p = 12'h0A0;
                  default: ;
               endcase
            end
            8'h0F: code = EFF_SPEED;
            8'h10: begin
               if (hi != 8'hE0) begin
                  code = EFF_VOLSL;
                  if (hi == 8'hF0) p = {p[7:0], 4'hF};
                  else p = {2'b00, p[11:2]};
               end
            end
            8'h20: begin
               if (hi != 8'hE0) begin
                  code = EFF_VOLSL;
                  if (hi != 8'hF0) p = {2'b00, p[11:2]};
               end
            end
            8'h30: code = EFF_RETRIG;
            8'h40: code = EFF_TREMOLO;
            8'h50: code = EFF_TREMOR;
            RAW_OFFSET: begin
               if (p > 12'h0FF) p = 12'h0FF;
               code = EFF_OFFSET;
            end
            default: ;
         endcase
         return {code, p[7:0]};
      end
   endfunction

endpackage

// ===== src/tracker_track_unpacker.sv =====
// Top level of the packed track unpacker.
//   channel | ports                          | direction
//   req     | req_valid/req_stall, 2 fields  | in, one track byte per beat
//   rsp     | rsp_valid/rsp_stall, 9 fields  | out, one cell per beat
//   csr     | csr_wr_en, csr_wr_data[8:0]    | in, row count
// A byte that emits goes through the load state, where the row store read and cell
// build are captured, then gives one cell per cycle of a run (up to 64) while rsp_stall
// is low. A byte that only gathers or is ignored is taken without leaving idle.
// Synchronous active-high reset; row count resets to 64, row store is not cleared.
// req_stall is high while a cell run is set up or being emitted; rsp_stall holds it.
module tracker_track_unpacker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_track_byte,
   input  logic       req_first_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_row_index,
   output logic [7:0] rsp_note_value,
   output logic [7:0] rsp_instrument_number,
   output logic       rsp_volume_present,
   output logic [6:0] rsp_volume_level,
   output logic [4:0] rsp_effect_code,
   output logic [7:0] rsp_effect_param,
   output logic       rsp_last_of_run,
   output logic       rsp_track_done
);

   ttu_pkg::cmd_type    cmd;
   ttu_pkg::status_type status;

   ttu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ttu_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_track_byte        (req_track_byte),
      .req_first_byte        (req_first_byte),
      .rsp_row_index         (rsp_row_index),
      .rsp_note_value        (rsp_note_value),
      .rsp_instrument_number (rsp_instrument_number),
      .rsp_volume_present    (rsp_volume_present),
      .rsp_volume_level      (rsp_volume_level),
      .rsp_effect_code       (rsp_effect_code),
      .rsp_effect_param      (rsp_effect_param),
      .rsp_last_of_run       (rsp_last_of_run),
      .rsp_track_done        (rsp_track_done)
   );

endmodule

// ===== src/ttu_ctrl.sv =====
// Controller: accept, load and emit sequencing of the track unpacker.
module ttu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ttu_pkg::status_type status,
   output ttu_pkg::cmd_type    cmd
);

   ttu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttu_pkg::ST_IDLE: begin
            if (req_valid && status.emit) state_in = ttu_pkg::ST_LOAD;
         end
         ttu_pkg::ST_LOAD: state_in = ttu_pkg::ST_OUT;
         ttu_pkg::ST_OUT: begin
            if (!rsp_stall && status.last) state_in = ttu_pkg::ST_IDLE;
         end
         default: state_in = ttu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ttu_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ttu_pkg::ST_LOAD: cmd.load = 1'b1;
         ttu_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.take  = !rsp_stall;
         end
         default: ;
      endcase
   end

   a_load_to_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ttu_pkg::ST_LOAD |=> state_ff == ttu_pkg::ST_OUT)
      else $error("load not followed by output");
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      cmd.take && !status.last |=> state_ff == ttu_pkg::ST_OUT)
      else $error("run ended early");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.load, cmd.take}))
      else $error("overlapping commands");

endmodule

// ===== src/ttu_datapath.sv =====
// Datapath: parser, gathered fields, row store, cell build and result fields.
module ttu_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ttu_pkg::cmd_type    cmd,
   output ttu_pkg::status_type status,
   input  logic                csr_wr_en,
   input  logic [8:0]          csr_wr_data,
   input  logic [7:0]          req_track_byte,
   input  logic                req_first_byte,
   output logic [7:0]          rsp_row_index,
   output logic [7:0]          rsp_note_value,
   output logic [7:0]          rsp_instrument_number,
   output logic                rsp_volume_present,
   output logic [6:0]          rsp_volume_level,
   output logic [4:0]          rsp_effect_code,
   output logic [7:0]          rsp_effect_param,
   output logic                rsp_last_of_run,
   output logic                rsp_track_done
);

   logic [ttu_pkg::ROW_W-1:0] row_count_ff;
   logic [ttu_pkg::ROW_W-1:0] row_ff, row_in;
   logic                      finished_ff;
   logic [5:0]                pending_ff;
   logic [7:0]                g_note_ff, g_instr_ff, g_vol_ff, g_eff_ff, g_p1_ff, g_p2_ff;
   logic [ttu_pkg::RUN_W-1:0] count_ff;
   ttu_pkg::src_type          src_ff;
   ttu_pkg::cell_type         cell_ff;
   ttu_pkg::cell_type         rdata_ff;
   ttu_pkg::cell_type         store [ttu_pkg::ROW_MAX];
   ttu_pkg::cell_type         built;

   logic [ttu_pkg::ROW_W-1:0] limit;
   logic [ttu_pkg::ROW_W-1:0] row_eff;
   logic [ttu_pkg::ROW_W-1:0] row_next;
   logic                      drop;
   logic                      gathering;
   logic [5:0]                pend_eff, pend_low, pend_rest;
   logic [1:0]                action;
   logic [5:0]                xx;
   logic [ttu_pkg::ADDR_W-1:0] rd_addr;
   logic                      done_now;

   assign limit   = (row_count_ff > ttu_pkg::ROW_W'(ttu_pkg::ROW_MAX)) ?
                    ttu_pkg::ROW_W'(ttu_pkg::ROW_MAX) : row_count_ff;
   assign row_eff = req_first_byte ? '0 : row_ff;
   assign drop    = (!req_first_byte && finished_ff) || (row_eff >= limit);
   assign pend_eff  = req_first_byte ? 6'd0 : pending_ff;
   assign gathering = pend_eff != 6'd0;
   assign pend_low  = pend_eff & (~pend_eff + 6'd1);
   assign pend_rest = pend_eff & ~pend_low;
   assign action    = req_track_byte[1:0];
   assign xx        = req_track_byte[7:2];
   assign row_next  = row_ff + 1'b1;
   assign done_now  = row_next >= limit;

   always_comb begin
      status.emit = 1'b0;
      if (!drop) begin
         if (gathering) status.emit = pend_rest == 6'd0;
         else if (action == ttu_pkg::ACT_FULL) status.emit = xx == 6'd0;
         else status.emit = 1'b1;
      end
      status.last = (count_ff == '0) || done_now;
   end

   always_comb begin
      if (action == ttu_pkg::ACT_REPEAT) rd_addr = row_eff[ttu_pkg::ADDR_W-1:0] - 1'b1;
      else rd_addr = ttu_pkg::ADDR_W'(xx);
   end

   // Cell build from gathered bytes
   always_comb begin
      logic [8:0]  vsum;
      logic [7:0]  c1, c2;
      logic [11:0] p1, p2;
      logic [12:0] r1, r2;
      built = '0;
      built.note = g_note_ff;
      if (g_note_ff != 8'd0 && g_note_ff < ttu_pkg::NOTE_LIMIT) built.note = g_note_ff + 8'd12;
      built.instr = g_instr_ff;
      vsum = {1'b0, g_vol_ff} + 9'd1;
      if (g_vol_ff != 8'd0) begin
         built.vol_on = 1'b1;
         built.vol    = vsum[8:2];
      end
      c1 = g_eff_ff & 8'h0F;
      c2 = g_eff_ff & 8'hF0;
      p1 = {4'd0, g_p1_ff};
      p2 = {4'd0, g_p2_ff};
      if (c1 == 8'h0E && (g_p1_ff & 8'hF0) == 8'hF0 && c2 == 8'h00) begin
         p1 = {g_p1_ff[3:0], g_p2_ff};
         c1 = ttu_pkg::RAW_OFFSET;
         c2 = 8'h00;
         p2 = 12'd0;
      end
      r1 = ttu_pkg::map_effect(c1, p1);
      if (r1[12:8] != ttu_pkg::EFF_NONE) begin
         built.eff = r1[12:8];
         built.par = r1[7:0];
      end
      r2 = ttu_pkg::map_effect(c2, p2);
      if (built.eff != ttu_pkg::EFF_SPEED && built.eff != ttu_pkg::EFF_TEMPO &&
          built.eff != ttu_pkg::EFF_BREAK && r2[12:8] != ttu_pkg::EFF_NONE) begin
         built.eff = r2[12:8];
         built.par = r2[7:0];
      end
   end

   always_comb begin
      row_in = row_ff;
      if (cmd.accept) row_in = row_eff;
      else if (cmd.take) row_in = row_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ttu_pkg::ROW_COUNT_RESET;
         row_ff       <= '0;
         finished_ff  <= 1'b0;
         pending_ff   <= '0;
         g_note_ff    <= '0;
         g_instr_ff   <= '0;
         g_vol_ff     <= '0;
         g_eff_ff     <= '0;
         g_p1_ff      <= '0;
         g_p2_ff      <= '0;
      end else begin
         if (csr_wr_en) row_count_ff <= csr_wr_data;
         row_ff <= row_in;
         if (cmd.accept) begin
            finished_ff <= drop;
            pending_ff  <= pend_eff;
            if (!drop) begin
               if (gathering) begin
                  pending_ff <= pend_rest;
                  if (pend_low[0]) g_note_ff  <= req_track_byte;
                  if (pend_low[1]) g_instr_ff <= req_track_byte;
                  if (pend_low[2]) g_vol_ff   <= req_track_byte;
                  if (pend_low[3]) g_eff_ff   <= req_track_byte;
                  if (pend_low[4]) g_p1_ff    <= req_track_byte;
                  if (pend_low[5]) g_p2_ff    <= req_track_byte;
               end else begin
                  pending_ff <= 6'd0;
                  if (action == ttu_pkg::ACT_FULL) begin
                     pending_ff <= xx;
                     g_note_ff  <= '0;
                     g_instr_ff <= '0;
                     g_vol_ff   <= '0;
                     g_eff_ff   <= '0;
                     g_p1_ff    <= '0;
                     g_p2_ff    <= '0;
                  end
               end
            end
         end else if (cmd.take) begin
            finished_ff <= done_now;
         end
      end
   end

   // Run setup and source select, captured with each accepted byte; cell loaded in the load state
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         count_ff <= '0;
         src_ff   <= ttu_pkg::SRC_BUILD;
         if (!gathering) begin
            unique case (action)
               ttu_pkg::ACT_SKIP: begin
                  count_ff <= xx;
                  src_ff   <= ttu_pkg::SRC_EMPTY;
               end
               ttu_pkg::ACT_REPEAT: begin
                  count_ff <= xx;
                  src_ff   <= (row_eff == '0) ? ttu_pkg::SRC_EMPTY : ttu_pkg::SRC_MEM;
               end
               ttu_pkg::ACT_COPY: begin
                  src_ff <= (ttu_pkg::ROW_W'(xx) < row_eff) ? ttu_pkg::SRC_MEM :
                            ttu_pkg::SRC_EMPTY;
               end
               default: src_ff <= ttu_pkg::SRC_BUILD;
            endcase
         end
      end else if (cmd.take) begin
         count_ff <= count_ff - 1'b1;
      end
      if (cmd.load) begin
         case (src_ff)
            ttu_pkg::SRC_MEM:   cell_ff <= rdata_ff;
            ttu_pkg::SRC_BUILD: cell_ff <= built;
            default:            cell_ff <= '0;
         endcase
      end
   end

   // Row store
   always_ff @(posedge clock) begin
      if (cmd.take) store[row_ff[ttu_pkg::ADDR_W-1:0]] <= cell_ff;
      rdata_ff <= store[rd_addr];
   end

   assign rsp_row_index         = row_ff[ttu_pkg::ADDR_W-1:0];
   assign rsp_note_value        = cell_ff.note;
   assign rsp_instrument_number = cell_ff.instr;
   assign rsp_volume_present    = cell_ff.vol_on;
   assign rsp_volume_level      = cell_ff.vol;
   assign rsp_effect_code       = cell_ff.eff;
   assign rsp_effect_param      = cell_ff.par;
   assign rsp_last_of_run       = status.last;
   assign rsp_track_done        = done_now;

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> row_ff < limit)
      else $error("emit beyond row limit");
   a_not_finished: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> !finished_ff)
      else $error("emit after track finished");
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> row_ff == $past(row_next))
      else $error("row did not advance");

endmodule

// ===== tb/track_checker.sv =====
// Checker for the track unpacker: predicts cells from accepted bytes and compares rsp beats.
`timescale 1ns / 1ps
module track_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_track_byte,
   input  logic       req_first_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_row_index,
   input  logic [7:0] rsp_note_value,
   input  logic [7:0] rsp_instrument_number,
   input  logic       rsp_volume_present,
   input  logic [6:0] rsp_volume_level,
   input  logic [4:0] rsp_effect_code,
   input  logic [7:0] rsp_effect_param,
   input  logic       rsp_last_of_run,
   input  logic       rsp_track_done,
   output int         fail_count,
   output int         cells_pending
);

   // pending-byte flags of a full cell
   localparam logic [5:0] NEED_NOTE  = 6'h01;
   localparam logic [5:0] NEED_INSTR = 6'h02;
   localparam logic [5:0] NEED_VOL   = 6'h04;
   localparam logic [5:0] NEED_FX    = 6'h08;
   localparam logic [5:0] NEED_P1    = 6'h10;

   typedef struct {
      logic [7:0]        row;
      ttu_pkg::cell_type fields;
      logic              last;
      logic              done;
   } cell_beat_type;

   cell_beat_type     cell_q[$];
   ttu_pkg::cell_type row_store[ttu_pkg::ROW_MAX];
   logic [8:0] rows_cfg;
   logic [8:0] row_pos;
   logic [5:0] need;
   logic       gathering;
   logic       finished;
   logic [7:0] g_note, g_instr, g_vol, g_fx, g_p1, g_p2;

   assign cells_pending = cell_q.size();

   function automatic logic [8:0] rows_limit();
      return (rows_cfg < ttu_pkg::ROW_MAX) ? rows_cfg : 9'(ttu_pkg::ROW_MAX);
   endfunction

   function automatic void translate_fx(inout ttu_pkg::cell_type c, input logic [7:0] fx,
                                        input logic [11:0] d);
      logic [4:0]  code;
      logic [11:0] p;
      logic [7:0]  hi;
      logic [3:0]  lo;
      code = ttu_pkg::EFF_NONE;
      p    = d;
      hi   = d[7:0] & 8'hF0;
      lo   = d[3:0];
      case (fx)
         8'h01: code = ttu_pkg::EFF_PORTA_UP;
         8'h02: code = ttu_pkg::EFF_PORTA_DN;
         8'h03: code = ttu_pkg::EFF_TONE;
         8'h04: code = ttu_pkg::EFF_VIBRATO;
         8'h05: code = ttu_pkg::EFF_ARP;
         8'h07: code = (d < 12'h20) ? ttu_pkg::EFF_SPEED : ttu_pkg::EFF_TEMPO;
         8'h08: begin code = ttu_pkg::EFF_PAN; p = d << 1; end
         8'h0B: code = ttu_pkg::EFF_JUMP;
         8'h0C: code = ttu_pkg::EFF_GLOBVOL;
         8'h0D: begin code = ttu_pkg::EFF_BREAK; p = 12'(lo) + 12'(d[7:4]) * 12'd10; end
         8'h0E: begin
            code = ttu_pkg::EFF_EXT;
            case (hi)
               8'h00: code = ttu_pkg::EFF_NONE;
               8'h10: if (lo != 0) begin p = d | 12'h0F0; code = ttu_pkg::EFF_PANSL; end
                      else code = ttu_pkg::EFF_NONE;
               8'h20: if (lo != 0) begin p = {4'd0, lo, 4'hF}; code = ttu_pkg::EFF_PANSL; end
                      else code = ttu_pkg::EFF_NONE;
               8'h30: p = 12'(lo) | 12'h10;
               8'h40: p = 12'(lo) | 12'h30;
               8'h60: p = 12'(lo) | 12'hB0;
               8'h70: p = 12'(lo) | 12'h40;
               8'h90: begin code = ttu_pkg::EFF_RETRIG; p = 12'(lo); end
               8'hA0: begin code = ttu_pkg::EFF_GVSL; p = 12'(lo) << 4; end
               8'hB0: begin code = ttu_pkg::EFF_GVSL; p = 12'(lo); end
               8'hF0: p = 12'hA0;
               default: ;
            endcase
         end
         8'h0F: code = ttu_pkg::EFF_SPEED;
         8'h10: if (hi != 8'hE0) begin
            code = ttu_pkg::EFF_VOLSL;
            p = (hi == 8'hF0) ? ((d << 4) | 12'hF) : (d >> 2);
         end
         8'h20: if (hi != 8'hE0) begin
            code = ttu_pkg::EFF_VOLSL;
            if (hi != 8'hF0) p = d >> 2;
         end
         8'h30: code = ttu_pkg::EFF_RETRIG;
         8'h40: code = ttu_pkg::EFF_TREMOLO;
         8'h50: code = ttu_pkg::EFF_TREMOR;
         ttu_pkg::RAW_OFFSET: begin
            if (p > 12'hFF) p = 12'hFF;
            code = ttu_pkg::EFF_OFFSET;
         end
         default: ;
      endcase
      if (code != ttu_pkg::EFF_NONE) begin
         c.eff = code;
         c.par = p[7:0];
      end
   endfunction

   function automatic ttu_pkg::cell_type assemble_cell();
      ttu_pkg::cell_type c;
      logic [7:0]  fx1, fx2;
      logic [11:0] p1, p2;
      c = '0;
      c.note  = (g_note != 0 && g_note < ttu_pkg::NOTE_LIMIT) ? g_note + 8'd12 : g_note;
      c.instr = g_instr;
      if (g_vol != 0) begin
         c.vol_on = 1'b1;
         c.vol    = 7'((9'(g_vol) + 9'd1) >> 2);
      end
      fx1 = g_fx & 8'h0F;
      fx2 = g_fx & 8'hF0;
      p1  = 12'(g_p1);
      p2  = 12'(g_p2);
      // offset form: extended with F-high param and no second effect
      if (fx1 == 8'h0E && g_p1[7:4] == 4'hF && fx2 == 0) begin
         p1  = {g_p1[3:0], g_p2};
         fx1 = ttu_pkg::RAW_OFFSET;
         p2  = 0;
      end
      translate_fx(c, fx1, p1);
      if (c.eff != ttu_pkg::EFF_SPEED && c.eff != ttu_pkg::EFF_TEMPO &&
          c.eff != ttu_pkg::EFF_BREAK)
         translate_fx(c, fx2, p2);
      return c;
   endfunction

   function automatic void push_cell(ttu_pkg::cell_type c);
      cell_beat_type e;
      row_store[row_pos[7:0]] = c;
      e.row    = row_pos[7:0];
      e.fields = c;
      e.last   = 1'b0;
      row_pos = row_pos + 9'd1;
      if (row_pos >= rows_limit()) finished = 1'b1;
      e.done = finished;
      cell_q.push_back(e);
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic first);
      int       n0;
      logic [5:0] arg;
      ttu_pkg::cell_type c;
      if (first) begin
         row_pos = 0; gathering = 0; need = 0; finished = 0;
      end
      if (finished || row_pos >= rows_limit()) begin
         finished = 1'b1;
         return;
      end
      n0  = cell_q.size();
      arg = b[7:2];
      if (gathering && need != 0) begin
         if (need & NEED_NOTE) begin g_note = b; need &= ~NEED_NOTE; end
         else if (need & NEED_INSTR) begin g_instr = b; need &= ~NEED_INSTR; end
         else if (need & NEED_VOL) begin g_vol = b; need &= ~NEED_VOL; end
         else if (need & NEED_FX) begin g_fx = b; need &= ~NEED_FX; end
         else if (need & NEED_P1) begin g_p1 = b; need &= ~NEED_P1; end
         else begin g_p2 = b; need = 0; end
         if (need == 0) begin
            gathering = 0;
            push_cell(assemble_cell());
         end
      end else begin
         gathering = 0;
         case (b[1:0])
            ttu_pkg::ACT_SKIP:
               for (int i = 0; i <= arg && !finished; i++) push_cell('0);
            ttu_pkg::ACT_REPEAT:
               for (int i = 0; i <= arg && !finished; i++)
                  push_cell(row_pos != 0 ? row_store[row_pos[7:0] - 8'd1] :
                            ttu_pkg::cell_type'('0));
            ttu_pkg::ACT_COPY: begin
               // copy from a row not reached yet gives an empty cell
               c = (9'(arg) < row_pos) ? row_store[arg] : ttu_pkg::cell_type'('0);
               push_cell(c);
            end
            default: begin
               g_note = 0; g_instr = 0; g_vol = 0; g_fx = 0; g_p1 = 0; g_p2 = 0;
               need = arg;
               if (need != 0) gathering = 1'b1;
               else push_cell(assemble_cell());
            end
         endcase
      end
      if (cell_q.size() > n0) cell_q[$].last = 1'b1;
   endfunction

   task automatic report(string field, logic [7:0] got, logic [7:0] want);
      $display("%0t: cell mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cell_beat_type e;
      if (reset) begin
         rows_cfg = ttu_pkg::ROW_COUNT_RESET;
         row_pos = 0; need = 0; gathering = 0; finished = 0;
         g_note = 0; g_instr = 0; g_vol = 0; g_fx = 0; g_p1 = 0; g_p2 = 0;
         cell_q.delete();
      end else begin
         if (csr_wr_en) rows_cfg = csr_wr_data;
         if (req_valid && !req_stall) predict_byte(req_track_byte, req_first_byte);
         if (rsp_valid && !rsp_stall) begin
            if (cell_q.size() == 0) begin
               report("row_index of unexpected beat", rsp_row_index, 8'd0);
            end else begin
               e = cell_q.pop_front();
               if (rsp_row_index != e.row) report("row_index", rsp_row_index, e.row);
               if (rsp_note_value != e.fields.note)
                  report("note", rsp_note_value, e.fields.note);
               if (rsp_instrument_number != e.fields.instr)
                  report("instrument", rsp_instrument_number, e.fields.instr);
               if (rsp_volume_present != e.fields.vol_on)
                  report("volume_present", 8'(rsp_volume_present), 8'(e.fields.vol_on));
               if (rsp_volume_level != e.fields.vol)
                  report("volume_level", 8'(rsp_volume_level), 8'(e.fields.vol));
               if (rsp_effect_code != e.fields.eff)
                  report("effect_code", 8'(rsp_effect_code), 8'(e.fields.eff));
               if (rsp_effect_param != e.fields.par)
                  report("effect_param", rsp_effect_param, e.fields.par);
               if (rsp_last_of_run != e.last)
                  report("last_of_run", 8'(rsp_last_of_run), 8'(e.last));
               if (rsp_track_done != e.done)
                  report("track_done", 8'(rsp_track_done), 8'(e.done));
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// ===== tb/testbench.sv =====
// Top of the track unpacker testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

   localparam int CYCLE_LIMIT = 2000000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [8:0] csr_wr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_track_byte = '0;
   logic       req_first_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_row_index, rsp_note_value, rsp_instrument_number;
   logic       rsp_volume_present;
   logic [6:0] rsp_volume_level;
   logic [4:0] rsp_effect_code;
   logic [7:0] rsp_effect_param;
   logic       rsp_last_of_run, rsp_track_done;
   int         fail_count, cells_pending;
   int         cycles = 0;
   int         bytes_sent = 0;
   bit         gaps_on = 1'b0;
   bit         long_hold = 1'b0;

   always #5 clock = ~clock;

   tracker_track_unpacker u_dut (.*);

   track_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver side: random stall bursts, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic first = 1'b0);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_track_byte <= b;
      req_first_byte <= first;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (cells_pending != 0);
      // a gathering byte may still be in flight
      repeat (4) @(posedge clock);
   endtask

   task automatic set_rows(logic [8:0] n);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [7:0] full_hdr(logic [5:0] flags);
      return {flags, ttu_pkg::ACT_FULL};
   endfunction

   function automatic logic [7:0] run_hdr(logic [1:0] act, logic [5:0] arg);
      return {arg, act};
   endfunction

   task automatic full_cell(logic [5:0] flags, logic [7:0] nt, logic [7:0] ins,
                            logic [7:0] vol, logic [7:0] fx, logic [7:0] p1,
                            logic [7:0] p2);
      send_byte(full_hdr(flags));
      if (flags[0]) send_byte(nt);
      if (flags[1]) send_byte(ins);
      if (flags[2]) send_byte(vol);
      if (flags[3]) send_byte(fx);
      if (flags[4]) send_byte(p1);
      if (flags[5]) send_byte(p2);
   endtask

   function automatic logic [7:0] pick_fx();
      case ($urandom_range(0, 3))
         0: return {4'h0, 4'($urandom_range(0, 15))};
         1: return {4'($urandom_range(0, 5)), 4'h0};
         2: return {4'($urandom_range(0, 5)), 4'($urandom_range(0, 15))};
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic random_track();
      int nb;
      logic [5:0] flags;
      nb = $urandom_range(5, 30);
      send_byte(run_hdr(ttu_pkg::ACT_SKIP, 6'($urandom_range(0, 3))), 1'b1);
      for (int i = 0; i < nb; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: begin
               flags = 6'($urandom);
               full_cell(flags, 8'($urandom), 8'($urandom), 8'($urandom), pick_fx(),
                         ($urandom_range(0, 3) == 0) ? {4'hF, 4'($urandom)} : 8'($urandom),
                         8'($urandom));
            end
            9, 10: send_byte(run_hdr(ttu_pkg::ACT_SKIP, 6'($urandom_range(0, 6))));
            11, 12: send_byte(run_hdr(ttu_pkg::ACT_REPEAT, 6'($urandom_range(0, 6))));
            13, 14, 15: send_byte(run_hdr(ttu_pkg::ACT_COPY, 6'($urandom)));
            16: send_byte(run_hdr($urandom_range(0, 1) ? ttu_pkg::ACT_SKIP :
                                  ttu_pkg::ACT_REPEAT, 6'($urandom)));
            17: send_byte(8'($urandom));
            default: begin
               // broken cell: header and part of its bytes, then a new track
               send_byte(full_hdr(6'h3F));
               repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
               send_byte(8'($urandom), 1'b1);
            end
         endcase
      end
   endtask

   initial begin
      logic [8:0] rows;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default 64 rows, one 64-cell skip fills the track
      send_byte(run_hdr(ttu_pkg::ACT_SKIP, 6'h3F), 1'b1);
      send_byte(run_hdr(ttu_pkg::ACT_COPY, 6'h00));                  // ignored after last row
      send_byte(run_hdr(ttu_pkg::ACT_REPEAT, 6'h02), 1'b1);          // repeat at row 0
      send_byte(run_hdr(ttu_pkg::ACT_COPY, 6'h20));                  // copy ahead
      full_cell(6'h3F, 8'd107, 8'hFF, 8'hFF, 8'h0E, 8'hF3, 8'hC5);  // offset form
      full_cell(6'h1F, 8'd108, 8'h01, 8'h00, 8'h0E, 8'hF0, 8'h00);  // offset form, zero offset
      full_cell(6'h3F, 8'hFF, 8'h00, 8'h01, 8'h27, 8'h1F, 8'h40);   // speed blocks second
      full_cell(6'h3F, 8'h01, 8'h7F, 8'h80, 8'h1D, 8'h99, 8'hF3);   // break
      full_cell(6'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);   // no flags
      send_byte(run_hdr(ttu_pkg::ACT_COPY, 6'h04));
      send_byte(run_hdr(ttu_pkg::ACT_REPEAT, 6'h05));
      send_byte(full_hdr(6'h0F));
      send_byte(8'h30);
      send_byte(run_hdr(ttu_pkg::ACT_SKIP, 6'h01), 1'b1);            // cut mid-cell
      set_rows(9'd1);
      send_byte(run_hdr(ttu_pkg::ACT_REPEAT, 6'h3F), 1'b1);          // run cut short
      send_byte(8'hFF);
      set_rows(9'd256);
      send_byte(run_hdr(ttu_pkg::ACT_SKIP, 6'h3F), 1'b1);
      send_byte(run_hdr(ttu_pkg::ACT_REPEAT, 6'h3F));
      send_byte(run_hdr(ttu_pkg::ACT_REPEAT, 6'h3F));
      send_byte(run_hdr(ttu_pkg::ACT_SKIP, 6'h3F));

      // random part
      gaps_on = 1'b1;
      while (bytes_sent < 340) begin
         if (bytes_sent > 290) gaps_on = 1'b0;
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
               0: rows = 9'd1;
               1: rows = 9'd256;
               2: rows = ttu_pkg::ROW_COUNT_RESET;
               default: rows = 9'($urandom_range(1, 40));
            endcase
            set_rows(rows);
         end
         if (!long_hold && bytes_sent > 100 && bytes_sent < 130) begin
            long_hold = 1'b1;
            set_rows(9'd256);
            send_byte(run_hdr(ttu_pkg::ACT_SKIP, 6'h00), 1'b1);
            repeat (8) send_byte(run_hdr(ttu_pkg::ACT_SKIP, 6'h3F));
         end
         random_track();
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== tracker_track_unpacker.f =====
src/ttu_pkg.sv
src/ttu_ctrl.sv
src/ttu_datapath.sv
src/tracker_track_unpacker.sv
tb/track_checker.sv
tb/testbench.sv
